// ===== hdl/npc_pkg.sv =====
// ----------------------------------------------------------------------------
// npc_pkg
// Shared widths, types and codes of the nearest palette color core.
// ----------------------------------------------------------------------------
package npc_pkg;

  localparam int COLOR_W          = 8;
  localparam int WEIGHT_W         = 12;
  localparam int ENTRY_W          = 4;
  localparam int COLOR_INDEX_W    = 4;
  localparam int SCALED_W         = WEIGHT_W + COLOR_W;   // weight * diff
  localparam int SQ_W             = 2 * SCALED_W;         // squared term
  localparam int DIST_W           = SQ_W + 2;             // sum of three terms
  localparam int LANE_LAT         = 4;                    // register stages in a lane
  localparam int PALETTE_SIZE_DEF = 16;

  localparam int S_TDATA_W   = 32;
  localparam int M_TDATA_W   = 8;
  localparam int CFG_INDEX_W = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 12'd256;   // 1.0 in Q4.8

  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_RED   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_GREEN = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_BLUE  = 2'd2;

  typedef enum logic {
    KIND_QUERY = 1'b0,
    KIND_WRITE = 1'b1
  } kind_t;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] blue;
    logic [WEIGHT_W-1:0] green;
    logic [WEIGHT_W-1:0] red;
  } weights_t;

endpackage

// ===== hdl/nearest_palette_color_core.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_core
// Maps an RGB color to the index of the nearest entry of a palette, using a
// weighted squared distance (Q4.8 weights per channel), lowest index on ties.
// ----------------------------------------------------------------------------
//
//  channel | signals                       | word
//  --------+-------------------------------+------------------------------------
//  in      | s_tvalid s_tready s_tdata     | query color or palette write
//          | s_tuser                       |   (s_tuser: 0 query, 1 write)
//  out     | m_tvalid m_tready m_tdata     | nearest palette index, one per query
//  cfg     | cfg_valid cfg_ready cfg_index | channel weight write, always ready
//          | cfg_data                      |
//
// One word per cycle in while the output is not stalled. A query's index word
// passes through the register chain: input register, four lane stages (diff,
// scale, square, sum), then one register per level of the minimum tree.
// Palette writes take effect at the accepting edge and produce no output
// word. A stalled output word freezes every stage (s_tready
// low); empty slots move along with the pipe and are not squeezed out. Reset
// clears the stage valid bits and sets all weights to 1.0; palette contents
// are not reset and must be written before use.
// ----------------------------------------------------------------------------
module nearest_palette_color_core #(
  parameter int PALETTE_SIZE = npc_pkg::PALETTE_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [27:24] entry_index, [31:28] zero
  input  logic [npc_pkg::S_TDATA_W-1:0]     s_tdata,
  // [0] kind
  input  logic                              s_tuser,
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [3:0] color_index, [7:4] zero
  output logic [npc_pkg::M_TDATA_W-1:0]     m_tdata,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [npc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [npc_pkg::WEIGHT_W-1:0]      cfg_data
);

  localparam int IDX_W  = $clog2(PALETTE_SIZE);
  localparam int NSTAGE = 1 + npc_pkg::LANE_LAT + IDX_W;

  // input word unpack
  npc_pkg::rgb_t                 in_color;
  logic [npc_pkg::ENTRY_W-1:0]   in_entry;
  npc_pkg::kind_t                in_kind;

  assign in_color.red   = s_tdata[7:0];
  assign in_color.green = s_tdata[15:8];
  assign in_color.blue  = s_tdata[23:16];
  assign in_entry       = s_tdata[27:24];
  assign in_kind        = npc_pkg::kind_t'(s_tuser);

  // global advance: all stages move together unless the output word is stuck
  logic              vld [NSTAGE];
  logic              adv;
  logic              in_acc;

  assign adv      = !vld[NSTAGE-1] || m_tready;
  assign s_tready = adv;
  assign in_acc   = s_tvalid && s_tready;

  // weights
  npc_pkg::weights_t weights;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      weights.red   <= npc_pkg::WEIGHT_ONE;
      weights.green <= npc_pkg::WEIGHT_ONE;
      weights.blue  <= npc_pkg::WEIGHT_ONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        npc_pkg::REG_WEIGHT_RED:   weights.red   <= cfg_data;
        npc_pkg::REG_WEIGHT_GREEN: weights.green <= cfg_data;
        npc_pkg::REG_WEIGHT_BLUE:  weights.blue  <= cfg_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // palette: one register per slot, each feeding its own lane
  npc_pkg::rgb_t     palette [PALETTE_SIZE];
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;

  assign wr_en   = in_acc && (in_kind == npc_pkg::KIND_WRITE) &&
                   (32'(in_entry) < PALETTE_SIZE);
  assign wr_addr = IDX_W'(in_entry);

  always_ff @(posedge clk) begin
    for (int i = 0; i < PALETTE_SIZE; i++) begin
      if (wr_en && wr_addr == IDX_W'(i)) palette[i] <= in_color;
    end
  end

  // stage 0: query register; lanes read the palette behind it
  npc_pkg::rgb_t q_color;

  always_ff @(posedge clk) begin
    if (adv) q_color <= in_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSTAGE; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_acc && (in_kind == npc_pkg::KIND_QUERY);
      for (int k = 1; k < NSTAGE; k++) vld[k] <= vld[k-1];
    end
  end

  // distance lanes
  logic [npc_pkg::DIST_W-1:0] lane_dist [PALETTE_SIZE];

  for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_lane
    npc_dist u_dist (
      .clk     (clk),
      .en      (adv),
      .query   (q_color),
      .entry   (palette[i]),
      .weights (weights),
      .sq_dist (lane_dist[i])
    );
  end

  // minimum tree
  logic [IDX_W-1:0] best_idx;

  npc_argmin #(
    .N (PALETTE_SIZE)
  ) u_argmin (
    .clk       (clk),
    .en        (adv),
    .lane_dist (lane_dist),
    .best      (best_idx)
  );

  assign m_tvalid = vld[NSTAGE-1];
  assign m_tdata  = {{(npc_pkg::M_TDATA_W - npc_pkg::COLOR_INDEX_W){1'b0}},
                     npc_pkg::COLOR_INDEX_W'(best_idx)};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // a palette write never enters the result pipe
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_kind == npc_pkg::KIND_WRITE |=> !vld[0])
    else $error("palette write entered the result pipe");

  // a stall freezes the whole pipe
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> vld[0] == $past(vld[0]) && m_tvalid && $stable(best_idx))
    else $error("pipe moved during a stall");

  // with no word waiting at the output, input is always taken
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  // result index lies inside the palette
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> 32'(best_idx) < PALETTE_SIZE)
    else $error("result index outside palette");

endmodule

// ===== hdl/npc_dist.sv =====
// ----------------------------------------------------------------------------
// npc_dist
// Distance lane: weighted squared color distance of the query to one palette
// entry, four register stages (diff, scale, square, sum).
// ----------------------------------------------------------------------------
module npc_dist (
  input  logic                          clk,
  input  logic                          en,
  input  npc_pkg::rgb_t                 query,
  input  npc_pkg::rgb_t                 entry,
  input  npc_pkg::weights_t             weights,
  output logic [npc_pkg::DIST_W-1:0]    sq_dist
);

  logic [npc_pkg::COLOR_W-1:0]  diff_r, diff_g, diff_b;
  logic [npc_pkg::SCALED_W-1:0] scaled_r, scaled_g, scaled_b;
  logic [npc_pkg::SQ_W-1:0]     sq_r, sq_g, sq_b;

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= (query.red >= entry.red) ? query.red - entry.red : entry.red - query.red;
      diff_g <= (query.green >= entry.green) ?
                query.green - entry.green : entry.green - query.green;
      diff_b <= (query.blue >= entry.blue) ?
                query.blue - entry.blue : entry.blue - query.blue;

      scaled_r <= npc_pkg::SCALED_W'(weights.red) * npc_pkg::SCALED_W'(diff_r);
      scaled_g <= npc_pkg::SCALED_W'(weights.green) * npc_pkg::SCALED_W'(diff_g);
      scaled_b <= npc_pkg::SCALED_W'(weights.blue) * npc_pkg::SCALED_W'(diff_b);

      sq_r <= npc_pkg::SQ_W'(scaled_r) * npc_pkg::SQ_W'(scaled_r);
      sq_g <= npc_pkg::SQ_W'(scaled_g) * npc_pkg::SQ_W'(scaled_g);
      sq_b <= npc_pkg::SQ_W'(scaled_b) * npc_pkg::SQ_W'(scaled_b);

      sq_dist <= npc_pkg::DIST_W'(sq_r) + npc_pkg::DIST_W'(sq_g) + npc_pkg::DIST_W'(sq_b);
    end
  end

endmodule

// ===== hdl/npc_argmin.sv =====
// ----------------------------------------------------------------------------
// npc_argmin
// Registered pairwise minimum tree; one level per stage, left side wins ties.
// ----------------------------------------------------------------------------
module npc_argmin #(
  parameter int N = npc_pkg::PALETTE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [npc_pkg::DIST_W-1:0]    lane_dist [N],
  output logic [$clog2(N)-1:0]          best
);

  localparam int IDX_W  = $clog2(N);
  localparam int LEVELS = IDX_W;
  localparam int LEAVES = 1 << LEVELS;

  logic [npc_pkg::DIST_W-1:0] leaf_dist [LEAVES];
  logic [npc_pkg::DIST_W-1:0] node_dist [1:LEVELS][LEAVES/2];
  logic [IDX_W-1:0]           node_idx  [1:LEVELS][LEAVES/2];

  // leaves; padding is above any real distance so it never wins
  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < N) begin : g_real
      assign leaf_dist[j] = lane_dist[j];
    end else begin : g_pad
      assign leaf_dist[j] = '1;
    end
  end

  for (genvar l = 1; l <= LEVELS; l++) begin : g_level
    for (genvar j = 0; j < (LEAVES >> l); j++) begin : g_node
      logic [npc_pkg::DIST_W-1:0] left_dist, right_dist;
      logic [IDX_W-1:0]           left_idx, right_idx;

      if (l == 1) begin : g_from_leaf
        assign left_dist  = leaf_dist[2*j];
        assign right_dist = leaf_dist[2*j+1];
        assign left_idx   = IDX_W'(2*j);
        assign right_idx  = IDX_W'(2*j+1);
      end else begin : g_from_node
        assign left_dist  = node_dist[l-1][2*j];
        assign right_dist = node_dist[l-1][2*j+1];
        assign left_idx   = node_idx[l-1][2*j];
        assign right_idx  = node_idx[l-1][2*j+1];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          if (right_dist < left_dist) begin
            node_dist[l][j] <= right_dist;
            node_idx[l][j]  <= right_idx;
          end else begin
            node_dist[l][j] <= left_dist;
            node_idx[l][j]  <= left_idx;
          end
        end
      end
    end
  end

  assign best = node_idx[LEVELS][0];

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for nearest_palette_color_core. The bench keeps its own
// copy of the palette and the channel weights and works out the nearest entry
// for every accepted query. Each index word that comes out is checked against
// the oldest outstanding prediction. It runs a directed pass, then random
// phases under several weight settings, with random back-pressure on both
// streams and a long output hold-off that stalls the input.
// ----------------------------------------------------------------------------

// Palette and weight shadow, plus the queue of indexes still owed by the core.
class palette_match_board;
  npc_pkg::rgb_t                        palette [16];
  logic [npc_pkg::WEIGHT_W-1:0]         wt_red;
  logic [npc_pkg::WEIGHT_W-1:0]         wt_green;
  logic [npc_pkg::WEIGHT_W-1:0]         wt_blue;
  logic [npc_pkg::COLOR_INDEX_W-1:0]    owed_index [$];
  int                                   mismatches;

  function new();
    foreach (palette[i]) palette[i] = '0;
    wt_red     = npc_pkg::WEIGHT_ONE;
    wt_green   = npc_pkg::WEIGHT_ONE;
    wt_blue    = npc_pkg::WEIGHT_ONE;
    mismatches = 0;
  endfunction

  function void set_weight(logic [npc_pkg::CFG_INDEX_W-1:0] idx,
                           logic [npc_pkg::WEIGHT_W-1:0] data);
    case (idx)
      npc_pkg::REG_WEIGHT_RED:   wt_red   = data;
      npc_pkg::REG_WEIGHT_GREEN: wt_green = data;
      npc_pkg::REG_WEIGHT_BLUE:  wt_blue  = data;
      default: ;  // unmapped index: no effect
    endcase
  endfunction

  // (weight * |a - b|)^2, exact
  function longint unsigned weighted_sq(logic [npc_pkg::WEIGHT_W-1:0] w,
                                        logic [npc_pkg::COLOR_W-1:0] a,
                                        logic [npc_pkg::COLOR_W-1:0] b);
    longint unsigned diff;
    longint unsigned scaled;
    diff   = (a >= b) ? longint'(a - b) : longint'(b - a);
    scaled = longint'(w) * diff;
    return scaled * scaled;
  endfunction

  // scan upward, strict less-than keeps the lowest index on ties
  function logic [npc_pkg::COLOR_INDEX_W-1:0] nearest_entry(npc_pkg::rgb_t c);
    longint unsigned cand_dist;
    longint unsigned best_dist;
    int              best;
    best      = 0;
    best_dist = 0;
    for (int i = 0; i < 16; i++) begin
      cand_dist = weighted_sq(wt_red,   c.red,   palette[i].red)
                + weighted_sq(wt_green, c.green, palette[i].green)
                + weighted_sq(wt_blue,  c.blue,  palette[i].blue);
      if (i == 0 || cand_dist < best_dist) begin
        best_dist = cand_dist;
        best      = i;
      end
    end
    return best[npc_pkg::COLOR_INDEX_W-1:0];
  endfunction

  function void note_word(npc_pkg::kind_t kind, npc_pkg::rgb_t color,
                          logic [npc_pkg::ENTRY_W-1:0] slot);
    if (kind == npc_pkg::KIND_WRITE) begin
      palette[slot] = color;
    end else begin
      owed_index.push_back(nearest_entry(color));
    end
  endfunction

  function void check_index(logic [npc_pkg::COLOR_INDEX_W-1:0] got);
    logic [npc_pkg::COLOR_INDEX_W-1:0] want;
    if (owed_index.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected output word: color_index %0d", got);
    end else begin
      want = owed_index.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("color_index mismatch: expected %0d, got %0d", want, got);
      end
    end
  endfunction
endclass

module tb_top;

  localparam int PALETTE_ENTRIES = 16;
  localparam int PHASE_COUNT     = 8;
  localparam int PHASE_ITEMS     = 240;
  localparam int DRAIN_CYCLES    = 20;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int MAX_IDLE        = 13;
  localparam int WRITE_PCT       = 12;      // share of palette writes in random phases

  localparam logic [npc_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam logic [npc_pkg::WEIGHT_W-1:0]    WEIGHT_MAX   = 12'hFFF;
  localparam logic [npc_pkg::WEIGHT_W-1:0]    WEIGHT_ZERO  = 12'h000;

  logic                               clk;
  logic                               rst;
  logic                               s_tvalid;
  logic                               s_tready;
  logic [npc_pkg::S_TDATA_W-1:0]      s_tdata;    // [7:0] red, [15:8] green,
                                                  // [23:16] blue,
                                                  // [27:24] entry_index,
                                                  // [31:28] zero
  logic                               s_tuser;    // [0] kind
  logic                               m_tvalid;
  logic                               m_tready;
  logic [npc_pkg::M_TDATA_W-1:0]      m_tdata;    // [3:0] color_index, [7:4] zero
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [npc_pkg::CFG_INDEX_W-1:0]    cfg_index;
  logic [npc_pkg::WEIGHT_W-1:0]       cfg_data;

  palette_match_board board;

  // per-phase knobs shared by the driver processes
  bit sender_idle_en;
  bit receiver_idle_en;
  bit hold_off_due;

  nearest_palette_color_core #(
    .PALETTE_SIZE(PALETTE_ENTRIES)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop if the run hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic npc_pkg::rgb_t rgb_hex(logic [23:0] h);
    npc_pkg::rgb_t c;
    c.red   = h[23:16];
    c.green = h[15:8];
    c.blue  = h[7:0];
    return c;
  endfunction

  function automatic logic [npc_pkg::COLOR_W-1:0] nudge(logic [npc_pkg::COLOR_W-1:0] v);
    int n;
    n = int'(v) + int'($urandom_range(0, 6)) - 3;
    if (n < 0) n = 0;
    if (n > 255) n = 255;
    return n[npc_pkg::COLOR_W-1:0];
  endfunction

  function automatic logic [npc_pkg::COLOR_W-1:0] edge_or_any();
    case ($urandom_range(0, 2))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // query colors: half of them at or around palette entries, where the nearest choice
  // is close and ties are likely
  function automatic npc_pkg::rgb_t pick_query();
    npc_pkg::rgb_t c;
    npc_pkg::rgb_t base;
    int            mode;
    mode = $urandom_range(0, 99);
    base = board.palette[4'($urandom_range(0, PALETTE_ENTRIES - 1))];
    if (mode < 35) begin
      c = 24'($urandom_range(0, 24'hFFFFFF));
    end else if (mode < 65) begin
      c.red   = nudge(base.red);
      c.green = nudge(base.green);
      c.blue  = nudge(base.blue);
    end else if (mode < 85) begin
      c = base;
    end else begin
      c.red   = edge_or_any();
      c.green = edge_or_any();
      c.blue  = edge_or_any();
    end
    return c;
  endfunction

  function automatic logic [npc_pkg::WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 3))
      0:       return WEIGHT_ZERO;
      1:       return WEIGHT_MAX;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  // Entered at a falling edge; returns at the falling edge after the word was
  // taken, with s_tvalid still high so back-to-back words need no toggle.
  task automatic send_word(npc_pkg::kind_t kind, npc_pkg::rgb_t color,
                           logic [npc_pkg::ENTRY_W-1:0] slot);
    int gap;
    gap = sender_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'b0000, slot, color};
    do @(posedge clk); while (!s_tready);
    board.note_word(kind, color, slot);
    @(negedge clk);
  endtask

  // same convention as send_word: cfg_valid left high on return
  task automatic write_reg(logic [npc_pkg::CFG_INDEX_W-1:0] idx,
                           logic [npc_pkg::WEIGHT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.set_weight(idx, data);
    @(negedge clk);
  endtask

  // Wait for every owed index, then let the pipe run dry: palette writes
  // leave nothing to wait for, so a further drain wait follows.
  task automatic wait_drained();
    while (board.owed_index.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Output side: random stall per word, plus the long hold-off on request.
  initial begin
    int stall;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      stall = receiver_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      board.check_index(m_tdata[npc_pkg::COLOR_INDEX_W-1:0]);
      @(negedge clk);
    end
  end

  // Palette used by the directed pass: primaries, corners, an exact duplicate
  // (slots 5 and 6) and a pair equidistant from a gray (slots 0 and 14).
  logic [23:0] seed_palette [PALETTE_ENTRIES] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
    24'h0000FF, 24'h808080, 24'h808080, 24'h7F7F7F,
    24'hAA5500, 24'h00AA55, 24'h5500AA, 24'hFFFF00,
    24'h00FFFF, 24'hFF00FF, 24'h404040, 24'hC0C0C0
  };

  // black, white, duplicate tie, near gray, its neighbor, midpoint tie, near red
  logic [23:0] seed_queries [7] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'h818181,
    24'h7F7F7F, 24'h202020, 24'hFE0101
  };

  initial begin
    int            failures;
    npc_pkg::rgb_t color;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    board     = new();
    sender_idle_en   = 1'b1;
    receiver_idle_en = 1'b1;
    hold_off_due     = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed pass, reset weights (1.0 each); fill every slot first
    for (int i = 0; i < PALETTE_ENTRIES; i++)
      send_word(npc_pkg::KIND_WRITE, rgb_hex(seed_palette[i]),
                i[npc_pkg::ENTRY_W-1:0]);
    foreach (seed_queries[i])
      send_word(npc_pkg::KIND_QUERY, rgb_hex(seed_queries[i]),
                4'($urandom_range(0, 15)));
    s_tvalid <= 1'b0;
    wait_drained();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      // weight setting for the phase: zero, max, mixed extremes, 1.0, then random
      case (p)
        0: begin
          write_reg(npc_pkg::REG_WEIGHT_RED,   WEIGHT_ZERO);
          write_reg(npc_pkg::REG_WEIGHT_GREEN, WEIGHT_ZERO);
          write_reg(npc_pkg::REG_WEIGHT_BLUE,  WEIGHT_ZERO);
        end
        1: begin
          write_reg(npc_pkg::REG_WEIGHT_RED,   WEIGHT_MAX);
          write_reg(npc_pkg::REG_WEIGHT_GREEN, WEIGHT_MAX);
          write_reg(npc_pkg::REG_WEIGHT_BLUE,  WEIGHT_MAX);
        end
        2: begin
          write_reg(npc_pkg::REG_WEIGHT_RED,   WEIGHT_MAX);
          write_reg(npc_pkg::REG_WEIGHT_GREEN, WEIGHT_ZERO);
          write_reg(npc_pkg::REG_WEIGHT_BLUE,  12'd1);
          write_reg(REG_UNMAPPED, 12'($urandom_range(0, 4095)));  // must be dropped
        end
        3: begin
          write_reg(npc_pkg::REG_WEIGHT_RED,   npc_pkg::WEIGHT_ONE);
          write_reg(npc_pkg::REG_WEIGHT_GREEN, npc_pkg::WEIGHT_ONE);
          write_reg(npc_pkg::REG_WEIGHT_BLUE,  npc_pkg::WEIGHT_ONE);
        end
        default: begin
          write_reg(npc_pkg::REG_WEIGHT_RED,   pick_weight());
          write_reg(npc_pkg::REG_WEIGHT_GREEN, pick_weight());
          write_reg(npc_pkg::REG_WEIGHT_BLUE,  pick_weight());
        end
      endcase
      cfg_valid <= 1'b0;

      // some phases run with no idling; two of them stall the output long
      // enough for the core to back up into the input
      sender_idle_en   = ($urandom_range(0, 3) != 0);
      receiver_idle_en = ($urandom_range(0, 3) != 0);
      if (p == 1 || p == 5) begin
        sender_idle_en = 1'b0;
        hold_off_due   = 1'b1;
      end

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < WRITE_PCT) begin
          // rewrite a slot; copies of other entries keep ties coming
          if ($urandom_range(0, 2) == 0)
            color = board.palette[4'($urandom_range(0, PALETTE_ENTRIES - 1))];
          else
            color = 24'($urandom_range(0, 24'hFFFFFF));
          send_word(npc_pkg::KIND_WRITE, color, 4'($urandom_range(0, 15)));
        end else begin
          send_word(npc_pkg::KIND_QUERY, pick_query(), 4'($urandom_range(0, 15)));
        end
      end
      s_tvalid <= 1'b0;
      wait_drained();
    end

    failures = board.mismatches + board.owed_index.size();
    if (failures == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
